@@ design/crp_pkg.sv @@
// Shared types and constants for the cell reference parser.
package crp_pkg;

	localparam int COLUMN_BITS_DEFAULT = 16;
	localparam int ROW_BITS_DEFAULT = 24;

	localparam int CH_W = 8;
	localparam int LETTER_W = 5;
	localparam int ROW_ACC_W = 31;
	localparam int ROW_PROD_W = 35;

	localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CH_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [CH_W-1:0] CH_DIGIT_9 = 8'h39;

	localparam logic [ROW_PROD_W-1:0] ROW_LIMIT = 35'd2147483647;

	localparam logic [31:0] COL_MAX_RESET = 32'd32767;
	localparam logic [31:0] ROW_MAX_RESET = 32'd8388607;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_COL_MAX = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_MAX = 1'b1;

	typedef enum logic [2:0] {
		PH_START,
		PH_COL_DOLLAR,
		PH_LETTERS,
		PH_ROW_DOLLAR,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic push;
		logic ok;
		logic column_fixed;
		logic row_fixed;
	} res_ctrl_t;

endpackage

@@ design/crp_in_stage.sv @@
// Input register stage holding one character and its last flag.
module crp_in_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [crp_pkg::CH_W-1:0] s_tdata,
	input  logic                    s_tlast,
	input  logic                    out_free,
	output logic                    adv,
	output logic [crp_pkg::CH_W-1:0] ch_s1,
	output logic                    last_s1
);

	logic valid_s1;

	assign adv = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

@@ design/crp_parse.sv @@
// Parse state and per-character update of the column and row accumulators.
module crp_parse #(
	parameter int COLUMN_BITS = crp_pkg::COLUMN_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [crp_pkg::CH_W-1:0]       ch_s1,
	input  logic                          last_s1,
	output crp_pkg::res_ctrl_t            res_ctrl,
	output logic [COLUMN_BITS:0]          res_col,
	output logic [crp_pkg::ROW_ACC_W-1:0] res_row
);

	localparam int CPW = COLUMN_BITS + 1 + crp_pkg::LETTER_W;
	localparam logic [CPW-1:0] COL_CAP = CPW'(1) << COLUMN_BITS;

	crp_pkg::phase_t phase_q, phase_d;
	logic [COLUMN_BITS:0] col_q, col_d;
	logic [crp_pkg::ROW_ACC_W-1:0] row_q, row_d;
	logic too_big_q, too_big_d;
	logic fcol_q, fcol_d;
	logic frow_q, frow_d;
	logic failed_q, failed_d;

	logic is_upper, is_lower, is_letter, is_digit, is_dollar;
	logic [crp_pkg::LETTER_W-1:0] lv;
	logic [crp_pkg::CH_W-1:0] lv_wide;
	logic [CPW-1:0] col_prod;
	logic [COLUMN_BITS:0] col_next;
	logic [crp_pkg::CH_W-1:0] digit;
	logic [crp_pkg::ROW_PROD_W-1:0] row_prod;
	logic take_letter, take_digit;

	always_comb begin
		is_upper = ch_s1 inside {[crp_pkg::CH_UPPER_A:crp_pkg::CH_UPPER_Z]};
		is_lower = ch_s1 inside {[crp_pkg::CH_LOWER_A:crp_pkg::CH_LOWER_Z]};
		is_letter = is_upper || is_lower;
		is_digit = ch_s1 inside {[crp_pkg::CH_DIGIT_0:crp_pkg::CH_DIGIT_9]};
		is_dollar = ch_s1 == crp_pkg::CH_DOLLAR;
		lv_wide = is_upper ? (ch_s1 - crp_pkg::CH_UPPER_A + 8'd1)
			: (ch_s1 - crp_pkg::CH_LOWER_A + 8'd1);
		lv = lv_wide[crp_pkg::LETTER_W-1:0];
		col_prod = CPW'(col_q) * CPW'(26) + CPW'(lv);
		col_next = (col_prod > COL_CAP) ? COL_CAP[COLUMN_BITS:0] : col_prod[COLUMN_BITS:0];
		digit = ch_s1 - crp_pkg::CH_DIGIT_0;
		row_prod = (crp_pkg::ROW_PROD_W'(row_q) << 3) + (crp_pkg::ROW_PROD_W'(row_q) << 1)
			+ crp_pkg::ROW_PROD_W'(digit[3:0]);
	end

	// Next phase and failure.
	always_comb begin
		phase_d = phase_q;
		failed_d = failed_q;
		if (!failed_q) begin
			case (phase_q)
				crp_pkg::PH_START: begin
					if (is_dollar) begin
						phase_d = crp_pkg::PH_COL_DOLLAR;
					end else if (is_letter) begin
						phase_d = crp_pkg::PH_LETTERS;
					end else begin
						failed_d = 1'b1;
					end
				end
				crp_pkg::PH_COL_DOLLAR: begin
					if (is_letter) begin
						phase_d = crp_pkg::PH_LETTERS;
					end else begin
						failed_d = 1'b1;
					end
				end
				crp_pkg::PH_LETTERS: begin
					if (is_letter) begin
						phase_d = crp_pkg::PH_LETTERS;
					end else if (is_dollar) begin
						phase_d = crp_pkg::PH_ROW_DOLLAR;
					end else if (is_digit) begin
						phase_d = crp_pkg::PH_DIGITS;
					end else begin
						failed_d = 1'b1;
					end
				end
				crp_pkg::PH_ROW_DOLLAR, crp_pkg::PH_DIGITS: begin
					if (is_digit) begin
						phase_d = crp_pkg::PH_DIGITS;
					end else begin
						failed_d = 1'b1;
					end
				end
				default: begin
					failed_d = 1'b1;
				end
			endcase
		end
	end

	// Accumulators and flags.
	always_comb begin
		take_letter = !failed_q && is_letter && (phase_q == crp_pkg::PH_START
			|| phase_q == crp_pkg::PH_COL_DOLLAR || phase_q == crp_pkg::PH_LETTERS);
		take_digit = !failed_q && is_digit && (phase_q == crp_pkg::PH_LETTERS
			|| phase_q == crp_pkg::PH_ROW_DOLLAR || phase_q == crp_pkg::PH_DIGITS);
		col_d = take_letter ? col_next : col_q;
		row_d = row_q;
		too_big_d = too_big_q;
		if (take_digit && !too_big_q) begin
			row_d = row_prod[crp_pkg::ROW_ACC_W-1:0];
			too_big_d = row_prod > crp_pkg::ROW_LIMIT;
		end
		fcol_d = fcol_q || (!failed_q && is_dollar && phase_q == crp_pkg::PH_START);
		frow_d = frow_q || (!failed_q && is_dollar && phase_q == crp_pkg::PH_LETTERS);
	end

	always_comb begin
		res_ctrl.push = adv && last_s1;
		res_ctrl.ok = !failed_d && phase_d == crp_pkg::PH_DIGITS && !too_big_d
			&& row_d != '0 && col_d != '0;
		res_ctrl.column_fixed = fcol_d;
		res_ctrl.row_fixed = frow_d;
		res_col = col_d;
		res_row = row_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crp_pkg::PH_START;
			col_q <= '0;
			row_q <= '0;
			too_big_q <= 1'b0;
			fcol_q <= 1'b0;
			frow_q <= 1'b0;
			failed_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= crp_pkg::PH_START;
				col_q <= '0;
				row_q <= '0;
				too_big_q <= 1'b0;
				fcol_q <= 1'b0;
				frow_q <= 1'b0;
				failed_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				col_q <= col_d;
				row_q <= row_d;
				too_big_q <= too_big_d;
				fcol_q <= fcol_d;
				frow_q <= frow_d;
				failed_q <= failed_d;
			end
		end
	end

endmodule

@@ design/crp_out_stage.sv @@
// Result clamping and the output register of the result stream.
module crp_out_stage #(
	parameter int COLUMN_BITS = crp_pkg::COLUMN_BITS_DEFAULT,
	parameter int ROW_BITS = crp_pkg::ROW_BITS_DEFAULT,
	parameter int TDATA_W = ((3 + COLUMN_BITS + ROW_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crp_pkg::res_ctrl_t            res_ctrl,
	input  logic [COLUMN_BITS:0]          res_col,
	input  logic [crp_pkg::ROW_ACC_W-1:0] res_row,
	input  logic [COLUMN_BITS-1:0]        col_max,
	input  logic [ROW_BITS-1:0]           row_max,
	output logic                          out_free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [TDATA_W-1:0]            m_tdata
);

	logic [COLUMN_BITS-1:0] cmax, col_out;
	logic [ROW_BITS-1:0] rmax, row_out;

	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		cmax = (col_max == '0) ? COLUMN_BITS'(1) : col_max;
		rmax = (row_max == '0) ? ROW_BITS'(1) : row_max;
		col_out = (res_col > {1'b0, cmax}) ? cmax : res_col[COLUMN_BITS-1:0];
		row_out = (res_row > crp_pkg::ROW_ACC_W'(rmax)) ? rmax : res_row[ROW_BITS-1:0];
		if (!res_ctrl.ok) begin
			col_out = '0;
			row_out = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_ctrl.push) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ctrl.push) begin
			m_tdata <= TDATA_W'({res_ctrl.ok && res_ctrl.row_fixed,
				res_ctrl.ok && res_ctrl.column_fixed, row_out, col_out, res_ctrl.ok});
		end
	end

endmodule

@@ design/cell_reference_parser_unit.sv @@
// Top level of the A1-style cell reference parser.
//
// Characters of one reference arrive on the s_ stream, one per transaction,
// with s_tlast set on the final character. Each reference yields one result
// transaction on the m_ stream: a valid flag, the column and row numbers and
// the two fixed flags. Invalid references give zero fields.
// The block takes one character every cycle while no final character waits.
// A character is registered on acceptance and parsed in the following cycle;
// the result of a final character is registered in the output register as it advances.
// When the receiver stalls, the result waits in the output register while
// further non-final characters keep being accepted; a second final
// character waits in the input register until the output register frees.
// The cfg_ port writes col_max (index 0) and row_max (index 1).
// Reset clears the parse state, sets the limits to 32767 and 8388607 and
// empties both streams.
module cell_reference_parser_unit #(
	parameter int COLUMN_BITS = crp_pkg::COLUMN_BITS_DEFAULT,
	parameter int ROW_BITS = crp_pkg::ROW_BITS_DEFAULT,
	parameter int CFG_W = (COLUMN_BITS > ROW_BITS) ? COLUMN_BITS : ROW_BITS,
	parameter int TDATA_W = ((3 + COLUMN_BITS + ROW_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [crp_pkg::CH_W-1:0]         s_tdata, // ch
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// valid_res, column, row, column_fixed, row_fixed, zero pad
	output logic [TDATA_W-1:0]              m_tdata,
	input  logic                            cfg_we,
	input  logic [crp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]                cfg_data
);

	logic [COLUMN_BITS-1:0] col_max_q;
	logic [ROW_BITS-1:0] row_max_q;
	logic out_free, adv, last_s1;
	logic [crp_pkg::CH_W-1:0] ch_s1;
	crp_pkg::res_ctrl_t res_ctrl;
	logic [COLUMN_BITS:0] res_col;
	logic [crp_pkg::ROW_ACC_W-1:0] res_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_max_q <= crp_pkg::COL_MAX_RESET[COLUMN_BITS-1:0];
			row_max_q <= crp_pkg::ROW_MAX_RESET[ROW_BITS-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				crp_pkg::REG_COL_MAX: col_max_q <= cfg_data[COLUMN_BITS-1:0];
				crp_pkg::REG_ROW_MAX: row_max_q <= cfg_data[ROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	crp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.out_free (out_free),
		.adv      (adv),
		.ch_s1    (ch_s1),
		.last_s1  (last_s1)
	);

	crp_parse #(
		.COLUMN_BITS (COLUMN_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ch_s1    (ch_s1),
		.last_s1  (last_s1),
		.res_ctrl (res_ctrl),
		.res_col  (res_col),
		.res_row  (res_row)
	);

	crp_out_stage #(
		.COLUMN_BITS (COLUMN_BITS),
		.ROW_BITS    (ROW_BITS),
		.TDATA_W     (TDATA_W)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_ctrl (res_ctrl),
		.res_col  (res_col),
		.res_row  (res_row),
		.col_max  (col_max_q),
		.row_max  (row_max_q),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ test/cell_reference_parser_unit_tb.sv @@
// Self-checking testbench for the cell reference parser: random and directed references.
module cell_reference_parser_unit_tb;
	import crp_pkg::*;

	localparam int TDATA_W = 48;
	localparam int CFG_W = 24;
	localparam int COL_LSB = 1;
	localparam int ROW_LSB = 17;
	localparam int COL_FIX_BIT = 41;
	localparam int ROW_FIX_BIT = 42;
	localparam int PAD_LSB = 43;
	localparam int unsigned COL_SAT = 65536;
	localparam int SETTLE = 8;
	localparam int HOLD_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [7:0] ch;
		logic last;
	} char_item_t;

	typedef struct packed {
		logic ok;
		logic [15:0] column;
		logic [23:0] row;
		logic column_fixed;
		logic row_fixed;
	} cell_ref_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [CH_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_COL_MAX;
	logic [CFG_W-1:0] cfg_data = '0;

	char_item_t chars_pending[$];
	cell_ref_t cell_refs_due[$];
	int unsigned chars_queued = 0;
	int unsigned chars_accepted = 0;
	int unsigned errors = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic hold_wanted = 1'b0;
	logic hold_started = 1'b0;
	int unsigned hold_left = 0;
	longint cycle_count = 0;

	phase_t pr_phase = PH_START;
	int unsigned pr_col = 0;
	longint unsigned pr_row = 0;
	logic pr_row_big = 1'b0;
	logic pr_col_fixed = 1'b0;
	logic pr_row_fixed = 1'b0;
	logic pr_failed = 1'b0;
	logic [15:0] lim_col = 16'd32767;
	logic [23:0] lim_row = 24'd8388607;

	cell_reference_parser_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("ERROR %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	task automatic consume_char(input logic [7:0] c, input logic fin);
		logic [4:0] lv;
		logic dig;
		int unsigned col_nx;
		longint unsigned row_nx;
		logic big_nx;
		logic ok;
		int unsigned cmax;
		longint unsigned rmax;
		cell_ref_t r;
		lv = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			lv = 5'(c - CH_UPPER_A + 8'd1);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			lv = 5'(c - CH_LOWER_A + 8'd1);
		end
		dig = (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
		col_nx = pr_col * 26 + lv;
		if (col_nx > COL_SAT) begin
			col_nx = COL_SAT;
		end
		row_nx = pr_row;
		big_nx = pr_row_big;
		if (dig && !pr_row_big) begin
			row_nx = pr_row * 10 + 64'(c - CH_DIGIT_0);
			big_nx = row_nx > ROW_LIMIT;
		end
		if (!pr_failed) begin
			case (pr_phase)
			PH_START, PH_COL_DOLLAR: begin
				if (pr_phase == PH_START && c == CH_DOLLAR) begin
					pr_col_fixed = 1'b1;
					pr_phase = PH_COL_DOLLAR;
				end else if (lv != 0) begin
					pr_col = col_nx;
					pr_phase = PH_LETTERS;
				end else begin
					pr_failed = 1'b1;
				end
			end
			PH_LETTERS: begin
				if (lv != 0) begin
					pr_col = col_nx;
				end else if (c == CH_DOLLAR) begin
					pr_row_fixed = 1'b1;
					pr_phase = PH_ROW_DOLLAR;
				end else if (dig) begin
					pr_row = row_nx;
					pr_row_big = big_nx;
					pr_phase = PH_DIGITS;
				end else begin
					pr_failed = 1'b1;
				end
			end
			PH_ROW_DOLLAR, PH_DIGITS: begin
				if (dig) begin
					pr_row = row_nx;
					pr_row_big = big_nx;
					pr_phase = PH_DIGITS;
				end else begin
					pr_failed = 1'b1;
				end
			end
			default: begin
				pr_failed = 1'b1;
			end
			endcase
		end
		if (fin) begin
			ok = !pr_failed && pr_phase == PH_DIGITS && !pr_row_big && pr_row != 0 &&
				pr_col != 0;
			cmax = (lim_col == 0) ? 1 : lim_col;
			rmax = (lim_row == 0) ? 1 : lim_row;
			r.ok = ok;
			r.column = ok ? 16'((pr_col > cmax) ? cmax : pr_col) : 16'd0;
			r.row = ok ? 24'((pr_row > rmax) ? rmax : pr_row) : 24'd0;
			r.column_fixed = ok && pr_col_fixed;
			r.row_fixed = ok && pr_row_fixed;
			cell_refs_due.push_back(r);
			pr_phase = PH_START;
			pr_col = 0;
			pr_row = 0;
			pr_row_big = 1'b0;
			pr_col_fixed = 1'b0;
			pr_row_fixed = 1'b0;
			pr_failed = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		char_item_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				consume_char(s_tdata, s_tlast);
				chars_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (chars_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = chars_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.ch;
					s_tlast <= nxt.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_wanted && !hold_started) begin
				hold_started <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		cell_ref_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (cell_refs_due.size() == 0) begin
					report("unexpected result", m_tdata, 0);
				end else begin
					want = cell_refs_due.pop_front();
					if (m_tdata[0] !== want.ok)
						report("valid_res", m_tdata[0], want.ok);
					if (m_tdata[COL_LSB +: 16] !== want.column)
						report("column", m_tdata[COL_LSB +: 16], want.column);
					if (m_tdata[ROW_LSB +: 24] !== want.row)
						report("row", m_tdata[ROW_LSB +: 24], want.row);
					if (m_tdata[COL_FIX_BIT] !== want.column_fixed)
						report("column_fixed", m_tdata[COL_FIX_BIT], want.column_fixed);
					if (m_tdata[ROW_FIX_BIT] !== want.row_fixed)
						report("row_fixed", m_tdata[ROW_FIX_BIT], want.row_fixed);
					if (m_tdata[TDATA_W-1:PAD_LSB] !== '0)
						report("pad", m_tdata[TDATA_W-1:PAD_LSB], 0);
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cell_reference_parser_unit: mismatch");
			$finish;
		end
	end

	task automatic queue_bytes(input byte unsigned txt[$]);
		char_item_t it;
		foreach (txt[i]) begin
			it.ch = txt[i];
			it.last = (i == txt.size() - 1);
			chars_pending.push_back(it);
		end
		chars_queued += txt.size();
	endtask

	task automatic queue_text(input string s);
		byte unsigned txt[$];
		for (int i = 0; i < s.len(); i++) begin
			txt.push_back(s[i]);
		end
		queue_bytes(txt);
	endtask

	// Mostly well-formed references with random content; the rest is noise or damaged.
	task automatic queue_random_ref(output int unsigned n);
		byte unsigned near_miss[10] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h23,
			8'h25, 8'h20, 8'h00};
		byte unsigned txt[$];
		byte unsigned bad;
		int unsigned pick;
		int unsigned k;
		logic zeros;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(6, 1)) txt.push_back(8'($urandom));
		end else begin
			if ($urandom_range(1)) txt.push_back(CH_DOLLAR);
			k = ($urandom_range(9) == 0) ? $urandom_range(7, 4) : $urandom_range(3, 1);
			repeat (k) begin
				txt.push_back(($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) +
					8'($urandom_range(25)));
			end
			if ($urandom_range(1)) txt.push_back(CH_DOLLAR);
			k = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(7, 1);
			zeros = ($urandom_range(19) == 0);
			repeat (k) txt.push_back(CH_DIGIT_0 + (zeros ? 8'd0 : 8'($urandom_range(9))));
			if (pick >= 80) begin
				bad = $urandom_range(1) ? 8'($urandom) : near_miss[$urandom_range(9)];
				case ($urandom_range(2))
				0: begin
					txt[$urandom_range(txt.size() - 1)] = bad;
				end
				1: begin
					k = $urandom_range(txt.size() - 1, 1);
					while (txt.size() > k) void'(txt.pop_back());
				end
				default: begin
					txt.push_back($urandom_range(1) ? CH_DOLLAR : CH_UPPER_A);
				end
				endcase
			end
		end
		queue_bytes(txt);
		n = txt.size();
	endtask

	task automatic queue_random(input int unsigned n_chars);
		int unsigned done;
		int unsigned n;
		done = 0;
		while (done < n_chars) begin
			queue_random_ref(n);
			done += n;
		end
	endtask

	task automatic drain();
		while (chars_accepted != chars_queued || cell_refs_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limits(input logic [15:0] col, input logic [23:0] row);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_COL_MAX;
		cfg_data <= {8'($urandom), col};
		@(posedge clk);
		cfg_index <= REG_ROW_MAX;
		cfg_data <= row;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_col = col;
		lim_row = row;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 11;
		recv_idle_pct = 68;
		queue_text("$a$1");
		queue_text("Z0");
		queue_text("B2147483648");
		queue_text("AAAAAA9");
		queue_text("1");
		queue_text("A$");
		queue_random(180);
		drain();
		write_limits(16'hFFFF, 24'hFFFFFF);
		queue_random(200);
		drain();
		send_idle_pct = 68;
		recv_idle_pct = 11;
		write_limits(16'd1, 24'd1);
		queue_random(150);
		drain();
		write_limits(16'd0, 24'd0);
		queue_random(100);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limits(16'd702, 24'd1000000);
		hold_wanted = 1'b1;
		queue_random(220);
		drain();
		write_limits(16'($urandom_range(65535, 1)), 24'($urandom_range(16777215, 1)));
		queue_random(250);
		drain();
		if (errors == 0) begin
			$display("cell_reference_parser_unit: match");
		end else begin
			$display("cell_reference_parser_unit: mismatch");
		end
		$finish;
	end

endmodule
